// File: hdl/brs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, widths, codes and reset values of the bilinear resize sampler.
// ----------------------------------------------------------------------------
package brs_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_SRC_WIDTH_DEF  = 256;
    localparam int MAX_SRC_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF      = 16;

    // Fixed field widths.
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int STEP_W     = 24;
    localparam int DIM_REG_W  = 9;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int OUT_CHAN_W = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Commands.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_VALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE   = 3'd4;

    // Configuration reset values.
    localparam logic [DIM_REG_W-1:0] SRC_DIM_RST  = 9'd256;
    localparam logic [STEP_W-1:0]    STEP_RST     = 24'd10887;
    localparam logic [SIZE_W-1:0]    DST_SIZE_RST = 13'd1536;

    typedef struct packed {
        logic                 cmd;
        logic [COORD_W-1:0]   x_coord;
        logic [COORD_W-1:0]   y_coord;
        logic [CHAN_W-1:0]    red_in;
        logic [CHAN_W-1:0]    green_in;
        logic [CHAN_W-1:0]    blue_in;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_CHAN_W-1:0] red_out;
        logic [OUT_CHAN_W-1:0] green_out;
        logic [OUT_CHAN_W-1:0] blue_out;
    } rsp_item_t;

    // The four neighbors of one sample, packed RGB with red on top.
    typedef struct packed {
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p11;
    } quad_t;

endpackage
`default_nettype wire

// File: hdl/brs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface brs_req_if import brs_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface brs_rsp_if import brs_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/bilinear_resize_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_resize_sampler
// Align-corners bilinear resampler over an RGB frame store.
// ----------------------------------------------------------------------------
// A load transfer writes one RGB pixel into the frame store at (x_coord,
// y_coord) and answers with status 0, or with status 2 and no write if the
// pixel lies outside the configured source size. A sample transfer maps the
// output coordinate to the source as coord * step (Q8.16 by default), clamps
// at the last row and column, reads the four neighbors and returns the blend
// in Q8.8 per channel with status 1, or status 2 and zero colors when the
// coordinate is not below the output size. Items are handled one at a time: a
// load writes and goes to the result, an out-of-range sample ends at the
// coordinate check, and an in-range sample runs through the coordinate
// multiply, the clamp, the four reads of the single-port frame memory, one
// per cycle, and the two multiply stages of the blend. The result
// sits in an output register, so a new item is taken while it waits for its
// transfer. The frame store needs no clearing after reset; a sample that
// reaches a pixel never loaded returns unspecified colors. Configuration is
// meant to be written only while no item is in flight.
// ----------------------------------------------------------------------------
module bilinear_resize_sampler import brs_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    brs_req_if.sink                    req,
    brs_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW     = $clog2(MAX_SRC_WIDTH);
    localparam int YW     = $clog2(MAX_SRC_HEIGHT);
    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int POS_W  = COORD_W + STEP_W;
    localparam int IP_W   = POS_W - FRAC_BITS;
    localparam int CMP_W  = (IP_W > SIZE_W) ? IP_W : SIZE_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_MAP    = 4'd3;
    localparam logic [3:0] S_RD0    = 4'd4;
    localparam logic [3:0] S_RD1    = 4'd5;
    localparam logic [3:0] S_RD2    = 4'd6;
    localparam logic [3:0] S_RD3    = 4'd7;
    localparam logic [3:0] S_RDWAIT = 4'd8;
    localparam logic [3:0] S_BL1    = 4'd9;
    localparam logic [3:0] S_BL2    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Configuration registers.
    logic [DIM_REG_W-1:0] src_width_reg;
    logic [DIM_REG_W-1:0] src_height_reg;
    logic [STEP_W-1:0]    step_x_reg;
    logic [STEP_W-1:0]    step_y_reg;
    logic [SIZE_W-1:0]    dst_size_reg;

    // Control state.
    logic [3:0] state_reg, state_next;
    logic       out_valid_reg;
    logic       out_load;

    // Item payload and working registers.
    logic                 cmd_reg;
    logic [COORD_W-1:0]   xc_reg, yc_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [POS_W-1:0]     pos_x_reg, pos_y_reg;
    logic [XW-1:0]        x0_reg, x1_reg;
    logic [YW-1:0]        y0_reg, y1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    quad_t                quad_reg;
    logic [STATUS_W-1:0]  status_reg;
    rsp_item_t            out_data_reg;

    // Effective source size and range checks.
    logic [SIZE_W-1:0] w_eff, h_eff, w_m1, h_m1;
    logic              ld_ok, smp_ok;

    // Clamp results.
    logic [IP_W-1:0] ip_x, ip_y;
    logic            clamp_x, clamp_y;

    // Frame memory port.
    logic             mem_en, mem_we;
    logic [AW-1:0]    mem_addr;
    logic [PIX_W-1:0] mem_rdata;

    // Blend results.
    logic [OUT_CHAN_W-1:0] blend_red, blend_green, blend_blue;

    function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] row,
                                               input logic [XW-1:0] col);
        pix_addr = AW'(row) * AW'(MAX_SRC_WIDTH) + AW'(col);
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_RST;
            src_height_reg <= SRC_DIM_RST;
            step_x_reg     <= STEP_RST;
            step_y_reg     <= STEP_RST;
            dst_size_reg   <= DST_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[DIM_REG_W-1:0];
                REG_STEP_X:     step_x_reg     <= cfg_data[STEP_W-1:0];
                REG_STEP_Y:     step_y_reg     <= cfg_data[STEP_W-1:0];
                REG_DST_SIZE:   dst_size_reg   <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A size of zero counts as one; a size above the store is cut to it.
    always_comb
    begin
        if (src_width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (SIZE_W'(src_width_reg) > SIZE_W'(MAX_SRC_WIDTH))
            w_eff = SIZE_W'(MAX_SRC_WIDTH);
        else
            w_eff = SIZE_W'(src_width_reg);

        if (src_height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (SIZE_W'(src_height_reg) > SIZE_W'(MAX_SRC_HEIGHT))
            h_eff = SIZE_W'(MAX_SRC_HEIGHT);
        else
            h_eff = SIZE_W'(src_height_reg);
    end

    assign w_m1   = w_eff - SIZE_W'(1);
    assign h_m1   = h_eff - SIZE_W'(1);
    assign ld_ok  = (SIZE_W'(xc_reg) < w_eff) && (SIZE_W'(yc_reg) < h_eff);
    assign smp_ok = (SIZE_W'(xc_reg) < dst_size_reg) && (SIZE_W'(yc_reg) < dst_size_reg);

    // The integer part of the position picks the top-left neighbor. At or past
    // the last column (row) the neighbor pair collapses and the weight is zero.
    assign ip_x    = pos_x_reg[POS_W-1:FRAC_BITS];
    assign ip_y    = pos_y_reg[POS_W-1:FRAC_BITS];
    assign clamp_x = CMP_W'(ip_x) >= CMP_W'(w_m1);
    assign clamp_y = CMP_W'(ip_y) >= CMP_W'(h_m1);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = (req.data.cmd == CMD_LOAD) ? S_LOAD : S_MUL;
            end
            S_LOAD:   state_next = S_DONE;
            S_MUL:    state_next = smp_ok ? S_MAP : S_DONE;
            S_MAP:    state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_RD2;
            S_RD2:    state_next = S_RD3;
            S_RD3:    state_next = S_RDWAIT;
            S_RDWAIT: state_next = S_BL1;
            S_BL1:    state_next = S_BL2;
            S_BL2:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= req.data.cmd;
                xc_reg  <= req.data.x_coord;
                yc_reg  <= req.data.y_coord;
                pix_reg <= {req.data.red_in, req.data.green_in, req.data.blue_in};
            end
            S_LOAD:
            begin
                status_reg <= ld_ok ? STATUS_LOADED : STATUS_RANGE;
            end
            S_MUL:
            begin
                pos_x_reg  <= POS_W'(xc_reg) * POS_W'(step_x_reg);
                pos_y_reg  <= POS_W'(yc_reg) * POS_W'(step_y_reg);
                status_reg <= STATUS_RANGE;
            end
            S_MAP:
            begin
                if (clamp_x)
                begin
                    x0_reg <= w_m1[XW-1:0];
                    x1_reg <= w_m1[XW-1:0];
                    fx_reg <= '0;
                end
                else
                begin
                    x0_reg <= ip_x[XW-1:0];
                    x1_reg <= ip_x[XW-1:0] + XW'(1);
                    fx_reg <= pos_x_reg[FRAC_BITS-1:0];
                end
                if (clamp_y)
                begin
                    y0_reg <= h_m1[YW-1:0];
                    y1_reg <= h_m1[YW-1:0];
                    fy_reg <= '0;
                end
                else
                begin
                    y0_reg <= ip_y[YW-1:0];
                    y1_reg <= ip_y[YW-1:0] + YW'(1);
                    fy_reg <= pos_y_reg[FRAC_BITS-1:0];
                end
            end
            // Read data is captured in the state after the one that issues its address.
            S_RD1:    quad_reg.p00 <= mem_rdata;
            S_RD2:    quad_reg.p01 <= mem_rdata;
            S_RD3:    quad_reg.p10 <= mem_rdata;
            S_RDWAIT: quad_reg.p11 <= mem_rdata;
            S_BL2:    status_reg   <= STATUS_VALID;
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_data_reg.status <= status_reg;
            if (status_reg == STATUS_VALID)
            begin
                out_data_reg.red_out   <= blend_red;
                out_data_reg.green_out <= blend_green;
                out_data_reg.blue_out  <= blend_blue;
            end
            else
            begin
                out_data_reg.red_out   <= '0;
                out_data_reg.green_out <= '0;
                out_data_reg.blue_out  <= '0;
            end
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Frame memory: loads write, samples read the four neighbors in turn.
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_en   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = pix_addr(y0_reg, x0_reg);
        unique case (state_reg)
            S_LOAD:
            begin
                mem_en   = ld_ok;
                mem_we   = 1'b1;
                mem_addr = pix_addr(yc_reg[YW-1:0], xc_reg[XW-1:0]);
            end
            S_RD0:
            begin
                mem_en   = 1'b1;
                mem_addr = pix_addr(y0_reg, x0_reg);
            end
            S_RD1:
            begin
                mem_en   = 1'b1;
                mem_addr = pix_addr(y0_reg, x1_reg);
            end
            S_RD2:
            begin
                mem_en   = 1'b1;
                mem_addr = pix_addr(y1_reg, x0_reg);
            end
            S_RD3:
            begin
                mem_en   = 1'b1;
                mem_addr = pix_addr(y1_reg, x1_reg);
            end
            default:
            begin
            end
        endcase
    end

    brs_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_frame_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (pix_reg),
        .rdata (mem_rdata)
    );

    brs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk   (clk),
        .quad  (quad_reg),
        .fx    (fx_reg),
        .fy    (fy_reg),
        .red   (blend_red),
        .green (blend_green),
        .blue  (blend_blue)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // One item at a time: after a request transfer no other is taken at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while an item is in flight");

    // The frame store is written only by an in-range load.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we) |-> (state_reg == S_LOAD && cmd_reg == CMD_LOAD && ld_ok))
        else $error("frame write outside an in-range load");

    // Neighbor indexes never pass the last column or row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD0) |->
            (SIZE_W'(x0_reg) <= w_m1) && (SIZE_W'(x1_reg) <= w_m1) &&
            (SIZE_W'(y0_reg) <= h_m1) && (SIZE_W'(y1_reg) <= h_m1))
        else $error("neighbor index beyond the source image");

    // Results other than a valid sample carry zero colors.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && status_reg != STATUS_VALID) |=>
            (rsp.data.red_out == '0) && (rsp.data.green_out == '0) &&
            (rsp.data.blue_out == '0))
        else $error("nonzero colors on a result that is not a sample");

endmodule
`default_nettype wire

// File: hdl/brs_frame_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_frame_mem
// Single-port synchronous frame store with a registered read.
// ----------------------------------------------------------------------------
module brs_frame_mem import brs_pkg::*; #(
    parameter int DEPTH  = MAX_SRC_WIDTH_DEF * MAX_SRC_HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [PIX_W-1:0]  wdata,
    output logic      [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                frame_mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= frame_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hdl/brs_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_blend
// Two-stage bilinear blend of four RGB neighbors, rounded to Q8.8.
// ----------------------------------------------------------------------------
module brs_blend import brs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire quad_t                 quad,
    input  wire logic [FRAC_BITS-1:0]  fx,
    input  wire logic [FRAC_BITS-1:0]  fy,
    output logic      [OUT_CHAN_W-1:0] red,
    output logic      [OUT_CHAN_W-1:0] green,
    output logic      [OUT_CHAN_W-1:0] blue
);

    localparam int WGT_W = FRAC_BITS + 1;
    localparam int TOP_W = FRAC_BITS + CHAN_W;
    localparam int ACC_W = 2 * FRAC_BITS + CHAN_W + 1;
    localparam int DROP  = 2 * FRAC_BITS - 8;

    localparam logic [WGT_W-1:0] ONE_FIX = WGT_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (DROP - 1);

    logic [WGT_W-1:0]      wx0;
    logic [WGT_W-1:0]      wy0;
    logic [OUT_CHAN_W-1:0] chan_out [3];

    assign wx0 = ONE_FIX - WGT_W'(fx);
    assign wy0 = ONE_FIX - WGT_W'(fy);

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        localparam int MSB = PIX_W - 1 - CHAN_W * c;

        logic [CHAN_W-1:0] v00, v01, v10, v11;
        logic [TOP_W:0]    top_sum, bot_sum;
        logic [TOP_W-1:0]  top_reg, bot_reg;
        logic [ACC_W-1:0]  acc_sum;
        logic [ACC_W-1:0]  acc_reg;

        assign v00 = quad.p00[MSB -: CHAN_W];
        assign v01 = quad.p01[MSB -: CHAN_W];
        assign v10 = quad.p10[MSB -: CHAN_W];
        assign v11 = quad.p11[MSB -: CHAN_W];

        // Horizontal pass: weights against the two pixels of each row.
        assign top_sum = (TOP_W+1)'(wx0) * (TOP_W+1)'(v00)
                       + (TOP_W+1)'(fx) * (TOP_W+1)'(v01);
        assign bot_sum = (TOP_W+1)'(wx0) * (TOP_W+1)'(v10)
                       + (TOP_W+1)'(fx) * (TOP_W+1)'(v11);

        // Vertical pass with the rounding constant folded in.
        assign acc_sum = ACC_W'(wy0) * ACC_W'(top_reg)
                       + ACC_W'(fy) * ACC_W'(bot_reg) + HALF;

        always_ff @(posedge clk)
        begin
            top_reg <= top_sum[TOP_W-1:0];
            bot_reg <= bot_sum[TOP_W-1:0];
            acc_reg <= acc_sum;
        end

        assign chan_out[c] = acc_reg[DROP + OUT_CHAN_W - 1 : DROP];
    end

    assign red   = chan_out[0];
    assign green = chan_out[1];
    assign blue  = chan_out[2];

endmodule
`default_nettype wire
